// ===== sv/decimal_hundredths_alu_defines.svh =====
// Assertion macros for the decimal hundredths ALU top level.
`ifndef DECIMAL_HUNDREDTHS_ALU_DEFINES_SVH
`define DECIMAL_HUNDREDTHS_ALU_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define DHA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also checks during reset.
`define DHA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/dha_pkg.sv =====
// Types and constants for the decimal hundredths ALU.
`default_nettype none
package dha_pkg;
    localparam int FIELD_W = 32;
    localparam int DIV_DW  = 63;  // dividend / quotient width
    localparam int DIV_RW  = 34;  // remainder / divisor width

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_MUL    = 2'd1;
    localparam logic [1:0] OP_DIV    = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;  // ignored: zero value, ok status

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    localparam logic [FIELD_W-1:0] SCALE     = 32'd100;
    localparam logic [FIELD_W-1:0] SCALE_X2  = 32'd200;
    localparam logic [DIV_DW-1:0]  HALF_SCALE = 63'd50;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [FIELD_W-1:0] lhs;
        logic signed [FIELD_W-1:0] rhs;
    } t_in;

    typedef struct packed {
        logic signed [FIELD_W-1:0] value;
        logic [1:0]                status;
    } t_out;

    // Side info that rides along the divider pipe.
    typedef struct packed {
        logic       neg;
        logic       special;
        logic [1:0] status;
    } t_side;
endpackage
`default_nettype wire

// ===== sv/dha_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module dha_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_vld,
    input  wire logic [dha_pkg::DIV_DW-1:0]  i_dividend,
    input  wire logic [dha_pkg::DIV_RW-1:0]  i_divisor,
    input  wire dha_pkg::t_side              i_side,
    output logic                             o_vld,
    output logic [dha_pkg::DIV_DW-1:0]       o_quot,
    output dha_pkg::t_side                   o_side
);
    localparam int N  = dha_pkg::DIV_DW;
    localparam int RW = dha_pkg::DIV_RW;

    logic                r_vld [N];
    logic [RW-1:0]       r_rem [N];
    logic [N-1:0]        r_dq  [N];
    logic [RW-1:0]       r_v   [N];
    dha_pkg::t_side      r_side[N];

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic          vin;
        logic [RW-1:0] rin;
        logic [N-1:0]  dqin;
        logic [RW-1:0] vv;
        dha_pkg::t_side sd;
        logic [RW-1:0] t;
        logic          ge;
        logic [RW-1:0] n_rem;

        if (s == 0) begin : g_first
            assign vin  = i_vld;
            assign rin  = '0;
            assign dqin = i_dividend;
            assign vv   = i_divisor;
            assign sd   = i_side;
        end else begin : g_next
            assign vin  = r_vld[s-1];
            assign rin  = r_rem[s-1];
            assign dqin = r_dq[s-1];
            assign vv   = r_v[s-1];
            assign sd   = r_side[s-1];
        end

        assign t     = {rin[RW-2:0], dqin[N-1]};
        assign ge    = (t >= vv);
        assign n_rem = ge ? (t - vv) : t;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= vin;
            end
            r_rem[s]  <= n_rem;
            r_dq[s]   <= {dqin[N-2:0], ge};
            r_v[s]    <= vv;
            r_side[s] <= sd;
        end
    end

    assign o_vld  = r_vld[N-1];
    assign o_quot = r_dq[N-1];
    assign o_side = r_side[N-1];
endmodule
`default_nettype wire

// ===== sv/decimal_hundredths_alu.sv =====
// Top level of the decimal hundredths ALU: add, multiply, divide in hundredths.
//
//  channel   ports                      handshake
//  -------   -------------------------  ------------------------------------
//  item in   i_item (op, lhs, rhs)      taken on start && !busy
//  result    o_item (value, status)     o_valid for one cycle, no stall
//
// Items pass stages 1 to 3, the divider and the final stage in order; one item per cycle.
// The divider is a 63-stage restoring divider, one quotient bit a stage.
// Every op runs through the divider: add divides by 1, multiply by 100,
// divide by twice the divisor, so latency is the same for all ops.
// Reset clears only the valid bits; busy is never raised.
`default_nettype none
`include "decimal_hundredths_alu_defines.svh"
module decimal_hundredths_alu #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire dha_pkg::t_in  i_item,
    output logic               o_valid,
    output dha_pkg::t_out      o_item
);
    localparam int FW  = dha_pkg::FIELD_W;
    localparam int DW  = dha_pkg::DIV_DW;
    localparam int RW  = dha_pkg::DIV_RW;
    // Result range width, capped at the output field.
    localparam int W   = (VALUE_BITS > FW) ? FW : VALUE_BITS;
    localparam logic [DW-1:0] POS_LIM = (DW'(1) << (W - 1)) - DW'(1);
    localparam logic [DW-1:0] NEG_LIM = DW'(1) << (W - 1);
    localparam int LAT = 3 + DW + 1;

    assign busy = 1'b0;

    // Stage 1: sign / magnitude split.
    logic          r1_vld;
    logic [1:0]    r1_op;
    logic          r1_na, r1_nb;
    logic [FW-1:0] r1_ma, r1_mb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start && !busy;
        end
        r1_op <= i_item.op;
        r1_na <= i_item.lhs[FW-1];
        r1_nb <= i_item.rhs[FW-1];
        r1_ma <= i_item.lhs[FW-1] ? (~i_item.lhs + FW'(1)) : i_item.lhs;
        r1_mb <= i_item.rhs[FW-1] ? (~i_item.rhs + FW'(1)) : i_item.rhs;
    end

    // Stage 2: multiply (also scales the divide numerator by 200) and add/sub.
    logic            r2_vld;
    logic [1:0]      r2_op;
    logic            r2_neg;
    logic [2*FW-1:0] r2_prod;
    logic [FW:0]     r2_sum;
    logic [FW-1:0]   r2_mb;
    logic [FW-1:0]   n_mop;
    logic            n_addneg;
    logic [FW:0]     n_sum;

    always_comb begin
        n_mop = (r1_op == dha_pkg::OP_MUL) ? r1_mb : dha_pkg::SCALE_X2;
        if (r1_na == r1_nb) begin
            n_sum    = {1'b0, r1_ma} + {1'b0, r1_mb};
            n_addneg = r1_na;
        end else if (r1_ma >= r1_mb) begin
            n_sum    = {1'b0, r1_ma - r1_mb};
            n_addneg = r1_na;
        end else begin
            n_sum    = {1'b0, r1_mb - r1_ma};
            n_addneg = r1_nb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_op   <= r1_op;
        r2_neg  <= (r1_op == dha_pkg::OP_ADD) ? n_addneg : (r1_na ^ r1_nb);
        r2_prod <= r1_ma * n_mop;
        r2_sum  <= n_sum;
        r2_mb   <= r1_mb;
    end

    // Stage 3: rounding offset, divisor select, special cases.
    logic           r3_vld;
    logic [DW-1:0]  r3_dividend;
    logic [RW-1:0]  r3_divisor;
    dha_pkg::t_side r3_side;
    logic [DW-1:0]  n_dividend;
    logic [RW-1:0]  n_divisor;
    dha_pkg::t_side n_side;

    always_comb begin
        n_side.neg     = r2_neg;
        n_side.special = 1'b0;
        n_side.status  = dha_pkg::ST_OK;
        n_dividend     = '0;
        n_divisor      = RW'(1);
        unique case (r2_op)
            dha_pkg::OP_ADD: begin
                n_dividend = DW'(r2_sum);
            end
            dha_pkg::OP_MUL: begin
                n_dividend = r2_prod[DW-1:0] + dha_pkg::HALF_SCALE;
                n_divisor  = RW'(dha_pkg::SCALE);
            end
            dha_pkg::OP_DIV: begin
                if (r2_mb == '0) begin
                    n_side.special = 1'b1;
                    n_side.status  = dha_pkg::ST_DIV0;
                end else begin
                    n_dividend = r2_prod[DW-1:0] + DW'(r2_mb);
                    n_divisor  = {1'b0, r2_mb, 1'b0};
                end
            end
            default: begin
                n_side.special = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_dividend <= n_dividend;
        r3_divisor  <= n_divisor;
        r3_side     <= n_side;
    end

    // Divider pipe.
    logic           d_vld;
    logic [DW-1:0]  d_quot;
    dha_pkg::t_side d_side;

    dha_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (r3_vld),
        .i_dividend (r3_dividend),
        .i_divisor  (r3_divisor),
        .i_side     (r3_side),
        .o_vld      (d_vld),
        .o_quot     (d_quot),
        .o_side     (d_side)
    );

    // Final stage: saturate and apply sign.
    logic          r_valid;
    dha_pkg::t_out r_item;
    dha_pkg::t_out n_item;
    logic          n_neg;
    logic [DW-1:0] n_mag;

    always_comb begin
        n_neg = d_side.neg && (d_quot != '0);
        n_mag = d_quot;
        n_item.status = dha_pkg::ST_OK;
        if (n_neg && (d_quot > NEG_LIM)) begin
            n_mag         = NEG_LIM;
            n_item.status = dha_pkg::ST_OVF;
        end else if (!n_neg && (d_quot > POS_LIM)) begin
            n_mag         = POS_LIM;
            n_item.status = dha_pkg::ST_OVF;
        end
        n_item.value = n_neg ? (~n_mag[FW-1:0] + FW'(1)) : n_mag[FW-1:0];
        if (d_side.special) begin
            n_item.value  = '0;
            n_item.status = d_side.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= d_vld;
        end
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    `DHA_ASSERT(a_latency, (start && !busy) |-> ##LAT o_valid, "result missing")
    `DHA_ASSERT(a_no_extra, o_valid |-> $past(start && !busy, LAT), "unexpected result")
    `DHA_ASSERT(a_div0,
        (start && i_item.op == dha_pkg::OP_DIV && i_item.rhs == '0) |->
            ##LAT (o_item.status == dha_pkg::ST_DIV0 && o_item.value == '0),
        "divide by zero status lost")
    `DHA_ASSERT_ALWAYS(a_no_busy, !busy, "busy raised")
endmodule
`default_nettype wire

// ===== verif/decimal_hundredths_alu_tb.sv =====
// Testbench for the decimal hundredths ALU: directed and random items checked against a predictor.
`default_nettype none
module decimal_hundredths_alu_tb;
    localparam int W = 32;            // result range width (VALUE_BITS capped at 32)
    localparam int LATENCY = 67;
    localparam int CYCLE_LIMIT = 200000;

    // Expected results, oldest first; checks each result as it comes out.
    class alu_scoreboard;
        dha_pkg::t_out pending[$];
        int            errors;

        function new();
            errors = 0;
        endfunction

        // Split a two's complement field into sign and magnitude.
        function void to_sign_mag(input logic [31:0] raw, output bit neg,
                                  output logic [63:0] mag);
            neg = raw[31];
            mag = raw[31] ? {32'd0, (~raw) + 32'd1} : {32'd0, raw};
            if (raw == 32'h8000_0000) mag = 64'h8000_0000;
        endfunction

        // Saturate to the W-bit range and build the result item.
        function dha_pkg::t_out saturate(input bit neg, input logic [63:0] mag);
            logic [63:0] pos_lim;
            logic [63:0] neg_lim;
            dha_pkg::t_out r;
            pos_lim = (64'd1 << (W - 1)) - 64'd1;
            neg_lim = 64'd1 << (W - 1);
            r.status = dha_pkg::ST_OK;
            if (mag == 0) neg = 0;
            if (neg) begin
                if (mag > neg_lim) begin
                    mag = neg_lim;
                    r.status = dha_pkg::ST_OVF;
                end
                r.value = (~mag[31:0]) + 32'd1;
            end else begin
                if (mag > pos_lim) begin
                    mag = pos_lim;
                    r.status = dha_pkg::ST_OVF;
                end
                r.value = mag[31:0];
            end
            return r;
        endfunction

        function dha_pkg::t_out compute(input dha_pkg::t_in it);
            bit na, nb;
            logic [63:0] ma, mb, q;
            dha_pkg::t_out r;
            to_sign_mag(it.lhs, na, ma);
            to_sign_mag(it.rhs, nb, mb);
            case (it.op)
                dha_pkg::OP_ADD: begin
                    if (na == nb) r = saturate(na, ma + mb);
                    else if (ma >= mb) r = saturate(na, ma - mb);
                    else r = saturate(nb, mb - ma);
                end
                dha_pkg::OP_MUL: begin
                    q = (ma * mb + 64'd50) / 64'd100;
                    r = saturate(na != nb, q);
                end
                dha_pkg::OP_DIV: begin
                    if (mb == 0) begin
                        r.value = '0;
                        r.status = dha_pkg::ST_DIV0;
                    end else begin
                        q = (64'd200 * ma + mb) / (64'd2 * mb);
                        r = saturate(na != nb, q);
                    end
                end
                default: begin
                    // unused op: zero result, ok status
                    r.value = '0;
                    r.status = dha_pkg::ST_OK;
                end
            endcase
            return r;
        endfunction

        function void note_item(input dha_pkg::t_in it);
            pending.push_back(compute(it));
        endfunction

        function void check_result(input dha_pkg::t_out got);
            dha_pkg::t_out exp_r;
            if (pending.size() == 0) begin
                $error("result with nothing expected: value %0d status %0d",
                       got.value, got.status);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.value !== exp_r.value) begin
                $error("value: expected %0d, got %0d", exp_r.value, got.value);
                errors++;
            end
            if (got.status !== exp_r.status) begin
                $error("status: expected %0d, got %0d", exp_r.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    dha_pkg::t_in  i_item;
    logic          o_valid;
    dha_pkg::t_out o_item;

    alu_scoreboard sb;
    int cycles;
    int idle_pct;   // percent chance that the sender idles before an item; drawn anew while it idles

    decimal_hundredths_alu uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_item (i_item),
        .o_valid(o_valid),
        .o_item (o_item)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Results are taken at the edge that ends their strobe cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_item);
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Boundary and random operand values.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return $urandom_range(0, 400) - 200;
            4: return $urandom_range(0, 2000000) - 1000000;
            5: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Drive one item; hold start until it is taken, with random gaps first.
    task automatic send_item(input logic [1:0] op, input logic [31:0] a,
                             input logic [31:0] b);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_item.op   <= op;
        i_item.lhs  <= a;
        i_item.rhs  <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_item('{op: op, lhs: a, rhs: b});
    endtask

    task automatic go_quiet();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 10 * LATENCY) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    initial begin
        int n;
        int ph;
        sb       = new();
        cycles   = 0;
        idle_pct = 0;
        start    = 1'b0;
        i_item   = '0;
        i_rst_n  = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, each op, rounding halves, overflow, divide by zero.
        send_item(dha_pkg::OP_ADD, 32'h7FFF_FFFF, 32'd1);          // positive overflow
        send_item(dha_pkg::OP_ADD, 32'h8000_0000, 32'hFFFF_FFFF);  // negative overflow
        send_item(dha_pkg::OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(dha_pkg::OP_ADD, 32'd150, -32'sd250);
        send_item(dha_pkg::OP_MUL, 32'd150, 32'd101);              // 151.5 -> half away
        send_item(dha_pkg::OP_MUL, -32'sd150, 32'd101);            // negative half
        send_item(dha_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);  // huge product
        send_item(dha_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(dha_pkg::OP_MUL, 32'd100, 32'h8000_0000);        // exact negative bound
        send_item(dha_pkg::OP_MUL, 32'd0, 32'hFFFF_FFFF);
        send_item(dha_pkg::OP_DIV, 32'd1, 32'd200);                // 0.5 -> half away
        send_item(dha_pkg::OP_DIV, -32'sd1, 32'd200);
        send_item(dha_pkg::OP_DIV, 32'd1234, 32'd0);               // divide by zero
        send_item(dha_pkg::OP_DIV, 32'h8000_0000, 32'd0);
        send_item(dha_pkg::OP_DIV, 32'h7FFF_FFFF, 32'd1);          // overflow
        send_item(dha_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(dha_pkg::OP_DIV, 32'h8000_0000, 32'h8000_0000);
        send_item(dha_pkg::OP_DIV, 32'd300, 32'd700);
        send_item(dha_pkg::OP_UNUSED, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(dha_pkg::OP_UNUSED, 32'h5555_5555, 32'hAAAA_AAAA);

        // Sender pauses until everything is back.
        go_quiet();
        wait_drained();

        // Random phases: no idling, mostly idle, lightly idle, none again.
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: idle_pct = 0;
                1: idle_pct = 66;
                2: idle_pct = 7;
                default: idle_pct = 0;
            endcase
            for (n = 0; n < 150; n++) begin
                logic [1:0] op;
                logic [31:0] a;
                logic [31:0] b;
                op = ($urandom_range(0, 19) == 0) ? dha_pkg::OP_UNUSED
                                                  : 2'($urandom_range(0, 2));
                a  = pick_operand();
                b  = pick_operand();
                send_item(op, a, b);
            end
        end
        go_quiet();

        wait_drained();
        repeat (LATENCY + 5) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            if (sb.pending.size() != 0)
                $error("%0d results never arrived", sb.pending.size());
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/dha_pkg.sv
sv/dha_div.sv
sv/decimal_hundredths_alu.sv
verif/decimal_hundredths_alu_tb.sv
